// ===== src/opus_id_header_parser_unit_assert.svh =====
// Assertion macros shared by the Opus identification header parser modules.
`ifndef OPUS_ID_HEADER_PARSER_UNIT_ASSERT_SVH
`define OPUS_ID_HEADER_PARSER_UNIT_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define OHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition in one cycle that must be followed by another in the next.
`define OHP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/ohp_pkg.sv =====
// Types and constants of the Opus identification header parser.
package ohp_pkg;

  // Header status codes, in order of priority.
  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_NOT_WHOLE = 4'd1,
    ST_GRANULE   = 4'd2,
    ST_PAGE      = 4'd3,
    ST_MAGIC     = 4'd4,
    ST_VERSION   = 4'd5,
    ST_TRUNC     = 4'd6,
    ST_ZERO_CH   = 4'd7,
    ST_FAM0_CH   = 4'd8,
    ST_COUPLED   = 4'd9,
    ST_LIMIT     = 4'd10,
    ST_MAP       = 4'd11
  } ohp_status_t;

  localparam logic KIND_MAP = 1'b0;
  localparam logic KIND_HDR = 1'b1;

  localparam logic [7:0] VERSION_MASK = 8'hF0;
  localparam logic [7:0] SILENT_ENTRY = 8'd255;
  localparam logic [8:0] MAP_START    = 9'd21;
  localparam logic [8:0] FAMILY_POS   = 9'd19;
  localparam logic [8:0] MAGIC_MIN    = 9'd9;
  localparam logic [8:0] MAGIC_LEN    = 9'd8;
  localparam logic [8:0] COUNT_MAX    = 9'd511;

  // Byte positions of the fixed header fields.
  localparam logic [8:0] POS_VERSION  = 9'd8;
  localparam logic [8:0] POS_CHANNELS = 9'd9;
  localparam logic [8:0] POS_PRESKIP0 = 9'd10;
  localparam logic [8:0] POS_PRESKIP1 = 9'd11;
  localparam logic [8:0] POS_RATE0    = 9'd12;
  localparam logic [8:0] POS_RATE1    = 9'd13;
  localparam logic [8:0] POS_RATE2    = 9'd14;
  localparam logic [8:0] POS_RATE3    = 9'd15;
  localparam logic [8:0] POS_GAIN0    = 9'd16;
  localparam logic [8:0] POS_GAIN1    = 9'd17;
  localparam logic [8:0] POS_FAMILY   = 9'd18;
  localparam logic [8:0] POS_STREAMS  = 9'd19;
  localparam logic [8:0] POS_COUPLED  = 9'd20;

  // "OpusHead"
  localparam logic [7:0] MAGIC_TEXT [8] = '{
    8'h4F, 8'h70, 8'h75, 8'h73, 8'h48, 8'h65, 8'h61, 8'h64
  };

  // Page flag bits as stored from the first byte.
  localparam int FLAG_WHOLE   = 0;
  localparam int FLAG_GRANULE = 1;
  localparam int FLAG_FIRST   = 2;
  localparam int FLAG_FINAL   = 3;

  // Work passed from the front end to the back end.
  typedef struct packed {
    logic        has_map;
    logic        has_hdr;
    logic [7:0]  map_index;
    logic [7:0]  map_entry;
    logic [8:0]  size;
    logic [3:0]  page_flags;
    logic        magic_ok;
    logic        map_bad;
    logic [7:0]  version;
    logic [7:0]  channels;
    logic [15:0] preskip;
    logic [31:0] rate;
    logic [15:0] gain;
    logic [7:0]  family;
    logic [7:0]  streams;
    logic [7:0]  coupled;
  } ohp_job_t;

  // One result item.
  typedef struct packed {
    logic        kind;
    logic [3:0]  status;
    logic [7:0]  version;
    logic [7:0]  channels;
    logic [15:0] preskip;
    logic [31:0] rate;
    logic [15:0] gain;
    logic [7:0]  family;
    logic [7:0]  streams;
    logic [7:0]  coupled;
    logic [7:0]  map_index;
    logic [7:0]  map_entry;
  } ohp_res_t;

endpackage

// ===== src/ohp_in_if.sv =====
// Input channel of the parser: one packet byte with its page flags.
interface ohp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       packet_whole;
  logic       granule_zero;
  logic       on_first_page;
  logic       on_final_page;

  modport source (
    output valid, data_byte, last_byte, packet_whole, granule_zero,
           on_first_page, on_final_page,
    input  ready
  );
  modport sink (
    input  valid, data_byte, last_byte, packet_whole, granule_zero,
           on_first_page, on_final_page,
    output ready
  );
endinterface

// ===== src/ohp_out_if.sv =====
// Result channel of the parser: map entries and header results.
interface ohp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [3:0]         status;
  logic [7:0]         version;
  logic [7:0]         channels;
  logic [15:0]        preskip;
  logic [31:0]        rate;
  logic signed [15:0] gain;
  logic [7:0]         family;
  logic [7:0]         streams;
  logic [7:0]         coupled;
  logic [7:0]         map_index;
  logic [7:0]         map_entry;

  modport source (
    output valid, kind, status, version, channels, preskip, rate, gain,
           family, streams, coupled, map_index, map_entry,
    input  ready
  );
  modport sink (
    input  valid, kind, status, version, channels, preskip, rate, gain,
           family, streams, coupled, map_index, map_entry,
    output ready
  );
endinterface

// ===== src/ohp_front.sv =====
// Front end: tracks the byte position, unpacks header fields and queues work.
`include "opus_id_header_parser_unit_assert.svh"
module ohp_front
  import ohp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  ohp_in_if.sink    in_chan,
  input  logic      queue_full,
  output logic      push,
  output ohp_job_t  job
);

  logic [8:0]  byte_count_r, byte_count_nxt;
  logic [3:0]  page_flags_r, page_flags_nxt;
  logic        magic_ok_r, magic_ok_nxt;
  logic        map_bad_r, map_bad_nxt;
  logic [7:0]  version_r, version_nxt;
  logic [7:0]  channels_r, channels_nxt;
  logic [15:0] preskip_r, preskip_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [15:0] gain_r, gain_nxt;
  logic [7:0]  family_r, family_nxt;
  logic [7:0]  streams_r, streams_nxt;
  logic [7:0]  coupled_r, coupled_nxt;

  logic       accept;
  logic       in_map;
  logic [7:0] b;
  logic [8:0] map_end;
  logic [8:0] map_limit;

  assign in_chan.ready = !queue_full;
  assign accept        = in_chan.valid && in_chan.ready;
  assign b             = in_chan.data_byte;

  // Map bytes run from position 21 up to 20 plus the channel count.
  assign map_end   = MAP_START + {1'b0, channels_r};
  assign map_limit = {1'b0, streams_r} + {1'b0, coupled_r};
  assign in_map    = (family_r != 8'd0) && (byte_count_r >= MAP_START) &&
                     (byte_count_r < map_end);

  always_comb begin
    page_flags_nxt = page_flags_r;
    magic_ok_nxt   = magic_ok_r;
    map_bad_nxt    = map_bad_r;
    version_nxt    = version_r;
    channels_nxt   = channels_r;
    preskip_nxt    = preskip_r;
    rate_nxt       = rate_r;
    gain_nxt       = gain_r;
    family_nxt     = family_r;
    streams_nxt    = streams_r;
    coupled_nxt    = coupled_r;

    if (byte_count_r == 9'd0) begin
      page_flags_nxt = {in_chan.on_final_page, in_chan.on_first_page,
                        in_chan.granule_zero, in_chan.packet_whole};
    end
    if ((byte_count_r < MAGIC_LEN) && (b != MAGIC_TEXT[byte_count_r[2:0]])) begin
      magic_ok_nxt = 1'b0;
    end

    unique case (byte_count_r)
      POS_VERSION:  version_nxt         = b;
      POS_CHANNELS: channels_nxt        = b;
      POS_PRESKIP0: preskip_nxt[7:0]    = b;
      POS_PRESKIP1: preskip_nxt[15:8]   = b;
      POS_RATE0:    rate_nxt[7:0]       = b;
      POS_RATE1:    rate_nxt[15:8]      = b;
      POS_RATE2:    rate_nxt[23:16]     = b;
      POS_RATE3:    rate_nxt[31:24]     = b;
      POS_GAIN0:    gain_nxt[7:0]       = b;
      POS_GAIN1:    gain_nxt[15:8]      = b;
      POS_FAMILY:   family_nxt          = b;
      POS_STREAMS:  streams_nxt         = b;
      POS_COUPLED:  coupled_nxt         = b;
      default:      ;
    endcase

    if (in_map && (b != SILENT_ENTRY) && ({1'b0, b} > map_limit)) begin
      map_bad_nxt = 1'b1;
    end

    byte_count_nxt = (byte_count_r == COUNT_MAX) ? byte_count_r : byte_count_r + 9'd1;
  end

  always_comb begin
    job.has_map    = in_map;
    job.has_hdr    = in_chan.last_byte;
    job.map_index  = 8'(byte_count_r - MAP_START);
    job.map_entry  = b;
    job.size       = byte_count_nxt;
    job.page_flags = page_flags_nxt;
    job.magic_ok   = magic_ok_nxt;
    job.map_bad    = map_bad_nxt;
    job.version    = version_nxt;
    job.channels   = channels_nxt;
    job.preskip    = preskip_nxt;
    job.rate       = rate_nxt;
    job.gain       = gain_nxt;
    job.family     = family_nxt;
    job.streams    = streams_nxt;
    job.coupled    = coupled_nxt;
  end

  assign push = accept && (in_map || in_chan.last_byte);

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_chan.last_byte)) begin
      byte_count_r <= '0;
      page_flags_r <= '0;
      magic_ok_r   <= 1'b1;
      map_bad_r    <= 1'b0;
      version_r    <= '0;
      channels_r   <= '0;
      preskip_r    <= '0;
      rate_r       <= '0;
      gain_r       <= '0;
      family_r     <= '0;
      streams_r    <= '0;
      coupled_r    <= '0;
    end else if (accept) begin
      byte_count_r <= byte_count_nxt;
      page_flags_r <= page_flags_nxt;
      magic_ok_r   <= magic_ok_nxt;
      map_bad_r    <= map_bad_nxt;
      version_r    <= version_nxt;
      channels_r   <= channels_nxt;
      preskip_r    <= preskip_nxt;
      rate_r       <= rate_nxt;
      gain_r       <= gain_nxt;
      family_r     <= family_nxt;
      streams_r    <= streams_nxt;
      coupled_r    <= coupled_nxt;
    end
  end

  `OHP_ASSERT_NEXT(a_last_clears_count, accept && in_chan.last_byte, byte_count_r == 9'd0, "byte count not cleared after last byte")
  `OHP_ASSERT(a_idle_state_clean, (byte_count_r == 9'd0) |-> (magic_ok_r && !map_bad_r), "parser state not clean at packet start")

endmodule

// ===== src/ohp_queue.sv =====
// Short queue of parsed work between the front end and the back end.
`include "opus_id_header_parser_unit_assert.svh"
module ohp_queue
  import ohp_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  ohp_job_t push_job,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output ohp_job_t head_job
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  ohp_job_t        mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic            do_pop;

  assign full       = (count_r == CntW'(Depth));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  `OHP_ASSERT(a_no_push_when_full, full |-> !push, "work written into a full queue")

endmodule

// ===== src/ohp_back.sv =====
// Back end: works out the header status and drives the result register.
`include "opus_id_header_parser_unit_assert.svh"
module ohp_back
  import ohp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  ohp_job_t  head_job,
  output logic      pop,
  ohp_out_if.source out_chan
);

  logic        out_valid_r, out_valid_nxt;
  ohp_res_t    res_r, res_nxt;
  logic        map_done_r, map_done_nxt;
  logic        load;
  ohp_status_t status;
  logic [8:0]  map_end;
  logic [8:0]  pair_sum;

  assign map_end  = MAP_START + {1'b0, head_job.channels};
  assign pair_sum = {1'b0, head_job.streams} + {1'b0, head_job.coupled};

  // First failing check in priority order wins.
  always_comb begin
    priority if (!head_job.page_flags[FLAG_WHOLE])        status = ST_NOT_WHOLE;
    else if (!head_job.page_flags[FLAG_GRANULE])          status = ST_GRANULE;
    else if (!head_job.page_flags[FLAG_FIRST] ||
             head_job.page_flags[FLAG_FINAL])             status = ST_PAGE;
    else if ((head_job.size < MAGIC_MIN) || !head_job.magic_ok) status = ST_MAGIC;
    else if ((head_job.version & VERSION_MASK) != 8'd0)   status = ST_VERSION;
    else if ((head_job.size < FAMILY_POS) ||
             ((head_job.family != 8'd0) && (head_job.size < map_end)))
                                                          status = ST_TRUNC;
    else if (head_job.channels == 8'd0)                   status = ST_ZERO_CH;
    else if (head_job.family == 8'd0)
      status = (head_job.channels > 8'd2) ? ST_FAM0_CH : ST_OK;
    else if (head_job.coupled > head_job.streams)         status = ST_COUPLED;
    else if (pair_sum > 9'd255)                           status = ST_LIMIT;
    else if (head_job.map_bad)                            status = ST_MAP;
    else                                                  status = ST_OK;
  end

  assign load = !out_valid_r || out_chan.ready;

  always_comb begin
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    map_done_nxt  = map_done_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = head_valid;
      if (head_valid) begin
        if (head_job.has_map && !map_done_r) begin
          res_nxt           = '0;
          res_nxt.kind      = KIND_MAP;
          res_nxt.map_index = head_job.map_index;
          res_nxt.map_entry = head_job.map_entry;
          map_done_nxt      = head_job.has_hdr;
          pop               = !head_job.has_hdr;
        end else begin
          res_nxt          = '0;
          res_nxt.kind     = KIND_HDR;
          res_nxt.status   = status;
          res_nxt.version  = head_job.version;
          res_nxt.channels = head_job.channels;
          res_nxt.preskip  = head_job.preskip;
          res_nxt.rate     = head_job.rate;
          res_nxt.gain     = head_job.gain;
          res_nxt.family   = head_job.family;
          if (head_job.family == 8'd0) begin
            res_nxt.streams = 8'd1;
            res_nxt.coupled = (head_job.channels == 8'd2) ? 8'd1 : 8'd0;
          end else begin
            res_nxt.streams = head_job.streams;
            res_nxt.coupled = head_job.coupled;
          end
          map_done_nxt = 1'b0;
          pop          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      map_done_r  <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      map_done_r  <= map_done_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.kind      = res_r.kind;
  assign out_chan.status    = res_r.status;
  assign out_chan.version   = res_r.version;
  assign out_chan.channels  = res_r.channels;
  assign out_chan.preskip   = res_r.preskip;
  assign out_chan.rate      = res_r.rate;
  assign out_chan.gain      = res_r.gain;
  assign out_chan.family    = res_r.family;
  assign out_chan.streams   = res_r.streams;
  assign out_chan.coupled   = res_r.coupled;
  assign out_chan.map_index = res_r.map_index;
  assign out_chan.map_entry = res_r.map_entry;

  `OHP_ASSERT(a_map_done_has_header, map_done_r |-> (head_valid && head_job.has_map && head_job.has_hdr), "pending header result without its work entry")

endmodule

// ===== src/opus_id_header_parser_unit.sv =====
// Top level of the Opus identification header parser.
//
// The in_chan channel takes one byte of an Ogg "OpusHead" packet per
// transfer, with last_byte marking the final byte; the four page flags
// are sampled on the first byte of each packet only.
// The out_chan channel gives two kinds of result. For a nonzero mapping
// family each channel-map byte is echoed as a map result (kind 0) as it
// arrives, and the last byte of the packet yields one header result
// (kind 1) with a status code and the unpacked header fields.
// A byte is taken every cycle while the work queue has room; a result
// is written into the queue when its byte is taken and then moves into
// the output register, from which out_chan presents it.
// A last byte that is also a map byte gives two results, map first,
// one after the other through the result register.
// If the receiver stalls, results wait in the output register and then
// in the queue of QUEUE_DEPTH entries, and in_chan.ready falls when
// that queue is full; while it is full no byte is taken at all, even
// one that would give no result.
// Reset clears the byte position and every header field, so the first
// byte after reset starts a new packet, and empties queue and output.
module opus_id_header_parser_unit
  import ohp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  ohp_in_if.sink    in_chan,
  ohp_out_if.source out_chan
);

  // Work handed from the front end into the queue.
  logic     push;
  ohp_job_t push_job;
  logic     queue_full;

  // Head of the queue as seen by the back end.
  logic     head_valid;
  ohp_job_t head_job;
  logic     pop;

  // The front end parses every byte in the cycle of its transfer.
  ohp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .queue_full (queue_full),
    .push       (push),
    .job        (push_job)
  );

  // Only bytes that produce results occupy a queue entry.
  ohp_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // The back end turns each entry into one or two result transfers.
  ohp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_chan   (out_chan)
  );

endmodule

// ===== dv/opus_id_header_parser_unit_tb.sv =====
// Self-checking testbench for the Opus identification header parser.
`timescale 1ns / 1ps

module opus_id_header_parser_unit_tb;
  import ohp_pkg::*;

  logic clk;
  logic rst_n;

  ohp_in_if  in_chan ();
  ohp_out_if out_chan ();

  opus_id_header_parser_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // Page flags are kept in the order that the block stores them, so that
  // FLAG_WHOLE and friends index them directly.
  localparam logic [3:0] FLAGS_GOOD = 4'b0111;

  // Results that the parser is known to owe, oldest first.
  ohp_res_t owed_results[$];

  // Bytes of the packet that is about to be sent.
  logic [7:0] pkt[$];

  int fail_count;
  int in_idle_pct;
  int out_idle_pct;

  // Our own view of the parser state, advanced on every accepted byte.
  int unsigned bytes_seen;
  logic [3:0]  pkt_flags;
  logic        magic_good;
  logic [7:0]  hdr_ver;
  logic [7:0]  hdr_chans;
  logic [15:0] hdr_skip;
  logic [31:0] hdr_srate;
  logic [15:0] hdr_gain_bits;
  logic [7:0]  hdr_fam;
  logic [7:0]  hdr_strm;
  logic [7:0]  hdr_cpl;
  logic        map_out_of_range;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // A generous ceiling: even the slowest legal run is far shorter.
  initial begin
    #(64'd40_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // Puts the tracked parser state back to what the block holds after reset
  // and after every header result.
  task automatic clear_parser();
    bytes_seen       = 0;
    pkt_flags        = '0;
    magic_good       = 1'b1;
    hdr_ver          = '0;
    hdr_chans        = '0;
    hdr_skip         = '0;
    hdr_srate        = '0;
    hdr_gain_bits    = '0;
    hdr_fam          = '0;
    hdr_strm         = '0;
    hdr_cpl          = '0;
    map_out_of_range = 1'b0;
  endtask

  // Appends one byte to the packet under construction.
  task automatic add_byte(input logic [7:0] b);
    pkt.insert(pkt.size(), b);
  endtask

  // Works out what one accepted byte makes the parser emit and queues it.
  task automatic parse_byte(input logic [7:0] b, input logic last, input logic [3:0] flags);
    int unsigned pos;
    int unsigned size;
    ohp_res_t    res;
    ohp_status_t st;
    pos = bytes_seen;
    if (pos == 0) pkt_flags = flags;
    if (pos < MAGIC_LEN && b != MAGIC_TEXT[pos]) magic_good = 1'b0;

    case (pos)
      POS_VERSION:  hdr_ver = b;
      POS_CHANNELS: hdr_chans = b;
      POS_PRESKIP0: hdr_skip[7:0] = b;
      POS_PRESKIP1: hdr_skip[15:8] = b;
      POS_RATE0:    hdr_srate[7:0] = b;
      POS_RATE1:    hdr_srate[15:8] = b;
      POS_RATE2:    hdr_srate[23:16] = b;
      POS_RATE3:    hdr_srate[31:24] = b;
      POS_GAIN0:    hdr_gain_bits[7:0] = b;
      POS_GAIN1:    hdr_gain_bits[15:8] = b;
      POS_FAMILY:   hdr_fam = b;
      POS_STREAMS:  hdr_strm = b;
      POS_COUPLED:  hdr_cpl = b;
      default: ;
    endcase

    // The channel map is echoed only for a nonzero family, and whatever
    // else has gone wrong with the header so far.
    if (hdr_fam != 0 && pos >= int'(MAP_START) && pos < int'(MAP_START) + int'(hdr_chans)) begin
      if (b != SILENT_ENTRY && int'(b) > int'(hdr_strm) + int'(hdr_cpl))
        map_out_of_range = 1'b1;
      res = '0;
      res.kind = KIND_MAP;
      res.map_index = 8'(pos - int'(MAP_START));
      res.map_entry = b;
      owed_results.insert(owed_results.size(), res);
    end

    if (bytes_seen < COUNT_MAX) bytes_seen++;
    size = bytes_seen;

    if (last) begin
      // The first failing check in order of the status codes wins.
      if (!pkt_flags[FLAG_WHOLE])
        st = ST_NOT_WHOLE;
      else if (!pkt_flags[FLAG_GRANULE])
        st = ST_GRANULE;
      else if (!pkt_flags[FLAG_FIRST] || pkt_flags[FLAG_FINAL])
        st = ST_PAGE;
      else if (size < MAGIC_MIN || !magic_good)
        st = ST_MAGIC;
      else if ((hdr_ver & VERSION_MASK) != 0)
        st = ST_VERSION;
      else if (size < FAMILY_POS ||
               (hdr_fam != 0 && size < int'(MAP_START) + int'(hdr_chans)))
        st = ST_TRUNC;
      else if (hdr_chans == 0)
        st = ST_ZERO_CH;
      else if (hdr_fam == 0)
        st = (hdr_chans > 2) ? ST_FAM0_CH : ST_OK;
      else if (hdr_cpl > hdr_strm)
        st = ST_COUPLED;
      else if (int'(hdr_strm) > 255 - int'(hdr_cpl))
        st = ST_LIMIT;
      else if (map_out_of_range)
        st = ST_MAP;
      else
        st = ST_OK;

      res = '0;
      res.kind = KIND_HDR;
      res.status = st;
      res.version = hdr_ver;
      res.channels = hdr_chans;
      res.preskip = hdr_skip;
      res.rate = hdr_srate;
      res.gain = hdr_gain_bits;
      res.family = hdr_fam;
      // Family 0 implies one stream, coupled only for stereo.
      if (hdr_fam == 0) begin
        res.streams = 8'd1;
        res.coupled = (hdr_chans == 2) ? 8'd1 : 8'd0;
      end else begin
        res.streams = hdr_strm;
        res.coupled = hdr_cpl;
      end
      owed_results.insert(owed_results.size(), res);
      clear_parser();
    end
  endtask

  // Sends one byte: an optional idle gap, then valid held until the
  // transfer. Valid is left high on return so that back-to-back bytes
  // follow without a gap; the next call or the drain decides what follows.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [3:0] flags);
    @(negedge clk);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= b;
    in_chan.last_byte     <= last;
    in_chan.packet_whole  <= flags[FLAG_WHOLE];
    in_chan.granule_zero  <= flags[FLAG_GRANULE];
    in_chan.on_first_page <= flags[FLAG_FIRST];
    in_chan.on_final_page <= flags[FLAG_FINAL];
    do @(posedge clk); while (!in_chan.ready);
    parse_byte(b, last, flags);
  endtask

  // Sends the bytes in pkt as one packet. The flags only matter on the
  // first byte; the rest carry random flags, which the block must ignore.
  task automatic send_packet(input logic [3:0] flags);
    int k;
    for (k = 0; k < pkt.size(); k++)
      send_byte(pkt[k], k == pkt.size() - 1, (k == 0) ? flags : 4'($urandom));
  endtask

  // Lowers valid, waits until every owed result has come out and then
  // goes on watching the result channel in case anything unexpected follows.
  task automatic wait_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Packets of one byte: each page flag fault, then a clean page whose
  // packet is too short to hold the magic.
  task automatic test_page_flags();
    pkt = '{8'h00};
    send_packet(4'b0110);
    pkt = '{8'hFF};
    send_packet(4'b0101);
    pkt = '{8'h4F};
    send_packet(4'b0011);
    send_packet(4'b1111);
    send_packet(FLAGS_GOOD);
    wait_drained();
  endtask

  // A well-formed family 1 header whose last byte is its only map byte,
  // so a map result and a header result come from the same transfer.
  // The numeric fields sit at their extremes.
  task automatic test_map_on_last_byte();
    int k;
    pkt.delete();
    for (k = 0; k < 8; k++) add_byte(MAGIC_TEXT[k]);
    add_byte(8'h0F);  // highest version that is still accepted
    add_byte(8'd1);   // channels
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'h00);  // gain at its most negative
    add_byte(8'h80);
    add_byte(8'd1);   // family
    add_byte(8'd1);   // streams
    add_byte(8'd0);   // coupled
    add_byte(8'd1);   // map entry
    send_packet(FLAGS_GOOD);
    wait_drained();
  endtask

  // Builds one packet in pkt. Most are plausible headers with random
  // content and some deliberate faults; a few are plain noise.
  task automatic build_random_packet(input bit long_tail);
    int unsigned chans;
    int unsigned fam;
    int unsigned strm;
    int unsigned cpl;
    int unsigned lim;
    int unsigned bad_idx;
    int unsigned k;
    int unsigned keep;
    logic [7:0]  ver;
    pkt.delete();

    if (!long_tail && $urandom_range(99, 0) < 8) begin
      repeat ($urandom_range(30, 1)) add_byte(8'($urandom));
      return;
    end

    ver = ($urandom_range(99, 0) < 85) ? 8'($urandom_range(15, 0))
                                       : 8'($urandom_range(255, 16));
    if ($urandom_range(99, 0) < 40) begin
      fam = 0;
      chans = ($urandom_range(99, 0) < 80) ? $urandom_range(2, 1)
            : (($urandom_range(1, 0) != 0) ? 0 : $urandom_range(255, 3));
    end else begin
      k = $urandom_range(99, 0);
      fam = (k < 50) ? 1 : ((k < 65) ? 255 : $urandom_range(255, 1));
      k = $urandom_range(99, 0);
      // Big channel counts make long packets, so they stay rare.
      chans = (k < 90) ? $urandom_range(8, 1) : ((k < 95) ? 0 : $urandom_range(255, 200));
    end

    k = $urandom_range(99, 0);
    if (k < 80) begin
      strm = $urandom_range((chans == 0) ? 1 : chans, 1);
      cpl = $urandom_range(strm, 0);
    end else if (k < 87) begin
      strm = $urandom_range(254, 0);
      cpl = $urandom_range(255, strm + 1);
    end else if (k < 94) begin
      strm = $urandom_range(255, 128);
      cpl = $urandom_range(strm, 256 - strm);
    end else begin
      strm = 0;
      cpl = 0;
    end
    lim = strm + cpl;
    bad_idx = ($urandom_range(99, 0) < 12) ? $urandom_range(chans, 0) : 256;

    for (k = 0; k < 8; k++) add_byte(MAGIC_TEXT[k]);
    add_byte(ver);
    add_byte(8'(chans));
    repeat (8) add_byte(8'($urandom));  // pre-skip, rate and gain
    add_byte(8'(fam));
    if (fam != 0) begin
      add_byte(8'(strm));
      add_byte(8'(cpl));
      for (k = 0; k < chans; k++) begin
        if (k == bad_idx && lim < 254)
          add_byte(8'($urandom_range(254, lim + 1)));
        else if ($urandom_range(99, 0) < 20)
          add_byte(SILENT_ENTRY);
        else
          add_byte(8'($urandom_range((lim > 255) ? 255 : lim, 0)));
      end
    end

    if ($urandom_range(99, 0) < 6)
      pkt[$urandom_range(7, 0)] ^= 8'($urandom_range(255, 1));
    if ($urandom_range(99, 0) < 12) begin
      keep = $urandom_range(pkt.size() - 1, 1);
      while (pkt.size() > keep) void'(pkt.pop_back());
    end
    if ($urandom_range(99, 0) < 15)
      repeat ($urandom_range(12, 1)) add_byte(8'($urandom));
    // A tail long enough to run the byte count into saturation.
    if (long_tail)
      repeat ($urandom_range(540, 515)) add_byte(8'($urandom));
  endtask

  // Random packets until roughly the given number of bytes has gone in.
  task automatic test_random_packets(input int budget, input bit with_long_packet);
    int sent;
    sent = 0;
    while (sent < budget) begin
      build_random_packet(with_long_packet && sent == 0);
      sent += pkt.size();
      send_packet(($urandom_range(99, 0) < 80) ? FLAGS_GOOD : 4'($urandom));
    end
    wait_drained();
  endtask

  // The receiver stalls at random in the share of cycles set by the test.
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99, 0) >= out_idle_pct);
  end

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Every transfer on the result channel is matched against the oldest
  // owed result.
  always @(posedge clk) begin
    ohp_res_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (owed_results.size() == 0) begin
        $error("result transfer with nothing owed: kind %0d status %0d",
               out_chan.kind, out_chan.status);
        fail_count++;
      end else begin
        want = owed_results.pop_front();
        check_field("kind", want.kind, out_chan.kind);
        check_field("status", want.status, out_chan.status);
        check_field("version", want.version, out_chan.version);
        check_field("channels", want.channels, out_chan.channels);
        check_field("preskip", want.preskip, out_chan.preskip);
        check_field("rate", want.rate, out_chan.rate);
        check_field("gain", want.gain, $unsigned(out_chan.gain));
        check_field("family", want.family, out_chan.family);
        check_field("streams", want.streams, out_chan.streams);
        check_field("coupled", want.coupled, out_chan.coupled);
        check_field("map_index", want.map_index, out_chan.map_index);
        check_field("map_entry", want.map_entry, out_chan.map_entry);
      end
    end
  end

  initial begin
    fail_count            = 0;
    in_idle_pct           = 33;
    out_idle_pct          = 61;
    rst_n                 = 1'b0;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = '0;
    in_chan.last_byte     = 1'b0;
    in_chan.packet_whole  = 1'b0;
    in_chan.granule_zero  = 1'b0;
    in_chan.on_first_page = 1'b0;
    in_chan.on_final_page = 1'b0;
    clear_parser();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_page_flags();
    test_map_on_last_byte();

    // Sender sparse and receiver sparser, then the other way round, then
    // both flat out; the saturating packet goes in the last phase.
    test_random_packets(190, 1'b0);
    in_idle_pct  = 61;
    out_idle_pct = 33;
    test_random_packets(190, 1'b0);
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_packets(190 + 530, 1'b1);

    if (fail_count == 0 && owed_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
